@@ src/tsps_pkg.sv @@
// ---------------------------------------------------------------------------
// tsps_pkg
// Shared types and constants of the solenoid pulse scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tsps_pkg;

   localparam int DefaultTableDepth    = 16;
   localparam int DefaultSolenoidCount = 32;

   localparam int TIME_W   = 32;
   localparam int LEN_W    = 16;
   localparam int TGT_W    = 5;
   localparam int MASK_W   = 32;
   localparam int SOL_W    = 6;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [LEN_W-1:0] DEFAULT_PULSE_RESET = 16'd20;

   typedef enum logic [MODE_W-1:0] {
      MODE_SCHEDULE = 2'd0,
      MODE_TICK     = 2'd1,
      MODE_CLEAR    = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE      = 3'd0,
      STATUS_SCHEDULED = 3'd1,
      STATUS_MERGED    = 3'd2,
      STATUS_FULL      = 3'd3,
      STATUS_BAD       = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      OP_ADD   = 2'd0,
      OP_REACH = 2'd1,
      OP_NEAR  = 2'd2
   } op_type;

   typedef struct packed {
      logic [TGT_W-1:0]  target;
      logic [TIME_W-1:0] start_ms;
      logic [LEN_W-1:0]  length_ms;
   } entry_type;

   typedef struct packed {
      op_type            op;
      logic [TIME_W-1:0] a;
      logic [TIME_W-1:0] b;
      logic [TIME_W-1:0] c;
   } unit_cmd_type;

endpackage

@@ src/tsps_unit.sv @@
// ---------------------------------------------------------------------------
// tsps_unit
// Shared time unit: one 32-bit add, reach compare or distance compare.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tsps_unit
   import tsps_pkg::*;
(
   input  unit_cmd_type      cmd,
   output logic [TIME_W-1:0] sum,
   output logic              flag
);

   logic [TIME_W-1:0] gap;

   always_comb begin
      sum = cmd.a + cmd.b;
      gap = (cmd.a > cmd.b) ? (cmd.a - cmd.b) : (cmd.b - cmd.a);
      case (cmd.op)
         OP_ADD:   flag = 1'b0;
         OP_REACH: flag = (cmd.c >= sum);
         OP_NEAR:  flag = (gap < cmd.c);
         default:  flag = 1'b0;
      endcase
   end

endmodule

@@ src/timed_solenoid_pulse_scheduler.sv @@
// ---------------------------------------------------------------------------
// timed_solenoid_pulse_scheduler
// Table of pending solenoid pulses against a millisecond counter.
//
// A command word is taken when start is high and busy is low: schedule,
// one millisecond tick, clear, or no-op. busy stays high until the result
// word has been produced. The result appears on the rsp_ ports for exactly
// one cycle with rsp_valid; the receiver cannot hold it off.
// For schedule and tick the sequencer walks the whole table, each entry
// read from memory and then passed through the shared time unit; clear,
// no-op and bad solenoid skip the walk. A new command can be taken in the
// cycle rsp_valid is shown.
// csr_ carries the default pulse width; it is always ready and is to be
// written only while the block is idle, which the block does not enforce.
// Reset clears the counter, all entries and all drive bits; the width
// register returns to 20 ms. The entry memory needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module timed_solenoid_pulse_scheduler
   import tsps_pkg::*;
#(
   parameter int TABLE_DEPTH    = DefaultTableDepth,
   parameter int SOLENOID_COUNT = DefaultSolenoidCount
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [SOL_W-1:0]    req_solenoid,
   input  logic [LEN_W-1:0]    req_delay_ms,
   input  logic [LEN_W-1:0]    req_width_ms,
   output logic                rsp_valid,
   output logic [MASK_W-1:0]   rsp_solenoid_mask,
   output logic                rsp_mask_changed,
   output logic [STATUS_W-1:0] rsp_status,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEN_W-1:0]    csr_default_pulse_ms
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [SOL_W-1:0] SOL_MAX  = SOL_W'(SOLENOID_COUNT);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_READ,
      S_EVAL,
      S_WRITE,
      S_CLEAR,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   mode_type              mode_ff, mode_in;
   status_type            status_ff, status_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  free_found_ff, free_found_in;
   logic                  merged_ff, merged_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [TIME_W-1:0]     fire_ff, fire_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [TGT_W-1:0]      tgt_ff, tgt_in;
   logic [LEN_W-1:0]      default_ff, default_in;
   logic [MASK_W-1:0]     drive_ff, drive_in;
   logic [MASK_W-1:0]     before_ff, before_in;
   logic [TABLE_DEPTH-1:0] busy_bits_ff, busy_bits_in;
   logic [TABLE_DEPTH-1:0] fired_bits_ff, fired_bits_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0]     rsp_mask_ff, rsp_mask_in;
   logic                  rsp_changed_ff, rsp_changed_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   entry_type             entry_mem_ff [TABLE_DEPTH];
   entry_type             rd_entry_ff;
   entry_type             wr_entry;
   logic                  mem_we;

   unit_cmd_type          unit_cmd;
   logic [TIME_W-1:0]     unit_sum;
   logic                  unit_flag;

   logic                  accept;
   logic                  ent_busy;
   logic                  ent_fired;
   logic [MASK_W-1:0]     ent_bit;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   assign ent_busy  = busy_bits_ff[idx_ff];
   assign ent_fired = fired_bits_ff[idx_ff];
   assign ent_bit   = MASK_W'(1) << rd_entry_ff.target;

   tsps_unit u_unit (
      .cmd  (unit_cmd),
      .sum  (unit_sum),
      .flag (unit_flag)
   );

   // operand selection for the shared unit
   always_comb begin
      unit_cmd.op = OP_ADD;
      unit_cmd.a  = now_ff;
      unit_cmd.b  = '0;
      unit_cmd.c  = now_ff;
      case (state_ff)
         S_PREP: begin
            // delay is parked in fire_ff at accept and added to now here; a tick adds one to now
            unit_cmd.op = OP_ADD;
            unit_cmd.a  = now_ff;
            unit_cmd.b  = (mode_ff == MODE_TICK) ? TIME_W'(1) : fire_ff;
         end
         S_EVAL: begin
            if (mode_ff == MODE_TICK) begin
               unit_cmd.op = OP_REACH;
               unit_cmd.a  = rd_entry_ff.start_ms;
               unit_cmd.b  = ent_fired ? TIME_W'(rd_entry_ff.length_ms) : '0;
               unit_cmd.c  = now_ff;
            end else begin
               unit_cmd.op = OP_NEAR;
               unit_cmd.a  = rd_entry_ff.start_ms;
               unit_cmd.b  = fire_ff;
               unit_cmd.c  = TIME_W'(len_ff);
            end
         end
         default: begin
            unit_cmd.op = OP_ADD;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      status_in      = status_ff;
      idx_in         = idx_ff;
      free_idx_in    = free_idx_ff;
      free_found_in  = free_found_ff;
      merged_in      = merged_ff;
      now_in         = now_ff;
      fire_in        = fire_ff;
      len_in         = len_ff;
      tgt_in         = tgt_ff;
      default_in     = default_ff;
      drive_in       = drive_ff;
      before_in      = before_ff;
      busy_bits_in   = busy_bits_ff;
      fired_bits_in  = fired_bits_ff;
      rsp_valid_in   = 1'b0;
      rsp_mask_in    = rsp_mask_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_status_in  = rsp_status_ff;
      mem_we         = 1'b0;
      wr_entry.target    = tgt_ff;
      wr_entry.start_ms  = fire_ff;
      wr_entry.length_ms = len_ff;

      if (csr_valid && csr_ready) begin
         default_in = csr_default_pulse_ms;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in       = mode_type'(req_mode);
               before_in     = drive_ff;
               status_in     = STATUS_DONE;
               idx_in        = '0;
               free_found_in = 1'b0;
               free_idx_in   = '0;
               merged_in     = 1'b0;
               tgt_in        = TGT_W'(req_solenoid - SOL_W'(1));
               fire_in       = TIME_W'(req_delay_ms);
               len_in        = (req_width_ms == '0) ? default_ff : req_width_ms;
               case (mode_type'(req_mode))
                  MODE_SCHEDULE: begin
                     if (req_solenoid == '0 || req_solenoid > SOL_MAX) begin
                        status_in = STATUS_BAD;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_PREP;
                     end
                  end
                  MODE_TICK:  state_in = S_PREP;
                  MODE_CLEAR: state_in = S_CLEAR;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_PREP: begin
            if (mode_ff == MODE_TICK) begin
               now_in = unit_sum;
            end else begin
               fire_in = unit_sum;
            end
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (mode_ff == MODE_TICK) begin
               if (ent_busy && unit_flag) begin
                  if (!ent_fired) begin
                     drive_in              = drive_ff | ent_bit;
                     fired_bits_in[idx_ff] = 1'b1;
                  end else begin
                     drive_in             = drive_ff & ~ent_bit;
                     busy_bits_in[idx_ff] = 1'b0;
                  end
               end
            end else begin
               if (ent_busy && !ent_fired && (rd_entry_ff.target == tgt_ff) && unit_flag) begin
                  merged_in = 1'b1;
               end
               if (!ent_busy && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
            end
            if (idx_ff == LAST_IDX) begin
               state_in = (mode_ff == MODE_TICK) ? S_DONE : S_WRITE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_READ;
            end
         end
         S_WRITE: begin
            if (merged_ff) begin
               status_in = STATUS_MERGED;
            end else if (free_found_ff) begin
               status_in                  = STATUS_SCHEDULED;
               mem_we                     = 1'b1;
               busy_bits_in[free_idx_ff]  = 1'b1;
               fired_bits_in[free_idx_ff] = 1'b0;
            end else begin
               status_in = STATUS_FULL;
            end
            state_in = S_DONE;
         end
         S_CLEAR: begin
            busy_bits_in  = '0;
            fired_bits_in = '0;
            drive_in      = '0;
            state_in      = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_mask_in    = drive_ff;
            rsp_changed_in = (drive_ff != before_ff);
            rsp_status_in  = status_ff;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         default_ff    <= DEFAULT_PULSE_RESET;
         drive_ff      <= '0;
         busy_bits_ff  <= '0;
         fired_bits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         default_ff    <= default_in;
         drive_ff      <= drive_in;
         busy_bits_ff  <= busy_bits_in;
         fired_bits_ff <= fired_bits_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      status_ff      <= status_in;
      idx_ff         <= idx_in;
      free_idx_ff    <= free_idx_in;
      free_found_ff  <= free_found_in;
      merged_ff      <= merged_in;
      fire_ff        <= fire_in;
      len_ff         <= len_in;
      tgt_ff         <= tgt_in;
      before_ff      <= before_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // entry memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem_ff[free_idx_ff] <= wr_entry;
      end
      rd_entry_ff <= entry_mem_ff[idx_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_solenoid_mask = rsp_mask_ff;
   assign rsp_mask_changed  = rsp_changed_ff;
   assign rsp_status        = rsp_status_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while sequencer busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_sched_no_change: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_DONE) |-> !rsp_mask_changed)
      else $error("schedule word changed drive bits");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |=> (drive_ff == '0 && busy_bits_ff == '0))
      else $error("clear left bits behind");

endmodule

@@ sim/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the solenoid pulse scheduler.
//
// A short table of directed command words comes first, a few of them with
// their result typed in, the rest checked by an in-bench model of the pulse
// table. Then random words are sent in bursts over several settings of the
// default pulse width. Each result word is compared, field by field, with
// the oldest expected one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import tsps_pkg::*;

   localparam int TABLE_DEPTH    = DefaultTableDepth;
   localparam int SOLENOID_COUNT = DefaultSolenoidCount;
   localparam int PHASES         = 6;
   localparam int PHASE_WORDS    = 270;
   localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + 8;
   localparam int CYCLE_LIMIT    = 1000000;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              changed;
      status_type        status;
   } pulse_result_type;

   typedef struct packed {
      mode_type          mode;
      logic [SOL_W-1:0]  sol;
      logic [LEN_W-1:0]  delay;
      logic [LEN_W-1:0]  width;
      logic              typed;
      pulse_result_type  want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [MODE_W-1:0]   req_mode = '0;
   logic [SOL_W-1:0]    req_solenoid = '0;
   logic [LEN_W-1:0]    req_delay_ms = '0;
   logic [LEN_W-1:0]    req_width_ms = '0;
   logic                rsp_valid;
   logic [MASK_W-1:0]   rsp_solenoid_mask;
   logic                rsp_mask_changed;
   logic [STATUS_W-1:0] rsp_status;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_default_pulse_ms = '0;

   // typed-in result travelling with the current word
   logic                row_typed = 1'b0;
   pulse_result_type    row_want = '0;

   timed_solenoid_pulse_scheduler #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .SOLENOID_COUNT (SOLENOID_COUNT)
   ) DUT (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_solenoid         (req_solenoid),
      .req_delay_ms         (req_delay_ms),
      .req_width_ms         (req_width_ms),
      .rsp_valid            (rsp_valid),
      .rsp_solenoid_mask    (rsp_solenoid_mask),
      .rsp_mask_changed     (rsp_mask_changed),
      .rsp_status           (rsp_status),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_default_pulse_ms (csr_default_pulse_ms)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   int cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // pulse table model
   logic [TIME_W-1:0] clock_ms;
   bit                slot_busy   [TABLE_DEPTH];
   bit                slot_fired  [TABLE_DEPTH];
   logic [TGT_W-1:0]  slot_target [TABLE_DEPTH];
   logic [TIME_W-1:0] slot_start  [TABLE_DEPTH];
   logic [LEN_W-1:0]  slot_len    [TABLE_DEPTH];
   logic [MASK_W-1:0] drive_mask;
   logic [LEN_W-1:0]  default_width;

   pulse_result_type expected_results [$];
   int               mismatches = 0;
   pulse_result_type want_word;
   pulse_result_type got_word;

   function automatic void drop_all_pulses();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_busy[i]  = 1'b0;
         slot_fired[i] = 1'b0;
      end
      drive_mask = '0;
   endfunction

   function automatic status_type schedule_pulse(logic [SOL_W-1:0] sol,
                                                 logic [LEN_W-1:0] delay,
                                                 logic [LEN_W-1:0] width);
      logic [TIME_W-1:0] fire_ms;
      logic [TIME_W-1:0] gap_ms;
      logic [LEN_W-1:0]  len;
      logic [TGT_W-1:0]  tgt;
      if (sol < 1 || sol > SOLENOID_COUNT)
         return STATUS_BAD;
      tgt     = TGT_W'(sol - 1);
      fire_ms = clock_ms + TIME_W'(delay);
      len     = (width == '0) ? default_width : width;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_busy[i] && !slot_fired[i] && slot_target[i] == tgt) begin
            gap_ms = (slot_start[i] > fire_ms) ? slot_start[i] - fire_ms
                                               : fire_ms - slot_start[i];
            if (gap_ms < TIME_W'(len))
               return STATUS_MERGED;
         end
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (!slot_busy[i]) begin
            slot_busy[i]   = 1'b1;
            slot_fired[i]  = 1'b0;
            slot_target[i] = tgt;
            slot_start[i]  = fire_ms;
            slot_len[i]    = len;
            return STATUS_SCHEDULED;
         end
      end
      return STATUS_FULL;
   endfunction

   function automatic void advance_ms();
      logic [MASK_W-1:0] sol_bit;
      logic [TIME_W-1:0] end_ms;
      clock_ms = clock_ms + 1;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_busy[i]) begin
            sol_bit = MASK_W'(1) << slot_target[i];
            end_ms  = slot_start[i] + TIME_W'(slot_len[i]);
            if (!slot_fired[i] && clock_ms >= slot_start[i]) begin
               drive_mask    = drive_mask | sol_bit;
               slot_fired[i] = 1'b1;
            end else if (slot_fired[i] && clock_ms >= end_ms) begin
               drive_mask   = drive_mask & ~sol_bit;
               slot_busy[i] = 1'b0;
            end
         end
      end
   endfunction

   function automatic pulse_result_type predict_word(mode_type mode, logic [SOL_W-1:0] sol,
                                                     logic [LEN_W-1:0] delay,
                                                     logic [LEN_W-1:0] width);
      pulse_result_type  res;
      logic [MASK_W-1:0] prev_mask;
      prev_mask  = drive_mask;
      res.status = STATUS_DONE;
      case (mode)
         MODE_SCHEDULE: res.status = schedule_pulse(sol, delay, width);
         MODE_TICK:     advance_ms();
         MODE_CLEAR:    drop_all_pulses();
         default:       ;
      endcase
      res.mask    = drive_mask;
      res.changed = (drive_mask != prev_mask);
      return res;
   endfunction

   // result check, then model update for the word taken at this edge
   always @(posedge clock) begin
      if (reset) begin
         clock_ms      = '0;
         default_width = DEFAULT_PULSE_RESET;
         drop_all_pulses();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result word with none expected: mask %h changed %0d status %0d",
                           rsp_solenoid_mask, rsp_mask_changed, rsp_status);
            end else begin
               want_word = expected_results.pop_front();
               if (rsp_solenoid_mask !== want_word.mask ||
                   rsp_mask_changed !== want_word.changed ||
                   rsp_status !== want_word.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: mask %h/%h changed %0d/%0d status %0d/%0d",
                              want_word.mask, rsp_solenoid_mask, want_word.changed,
                              rsp_mask_changed, want_word.status, rsp_status);
               end
            end
         end
         if (csr_valid && csr_ready)
            default_width = csr_default_pulse_ms;
         if (start && !busy) begin
            got_word = predict_word(mode_type'(req_mode), req_solenoid, req_delay_ms,
                                    req_width_ms);
            expected_results.push_back(row_typed ? row_want : got_word);
         end
      end
   end

   function automatic stim_row_type row(mode_type mode, int sol, int delay, int width,
                                        int typed, logic [MASK_W-1:0] mask, int changed,
                                        status_type status);
      stim_row_type r;
      r.mode         = mode;
      r.sol          = SOL_W'(sol);
      r.delay        = LEN_W'(delay);
      r.width        = LEN_W'(width);
      r.typed        = (typed != 0);
      r.want.mask    = mask;
      r.want.changed = (changed != 0);
      r.want.status  = status;
      return r;
   endfunction

   function automatic stim_row_type random_word();
      stim_row_type w;
      int           pick;
      w       = '0;
      w.sol   = SOL_W'($urandom);
      w.delay = LEN_W'($urandom);
      w.width = LEN_W'($urandom);
      pick    = $urandom_range(0, 99);
      if (pick < 46) begin
         w.mode = MODE_SCHEDULE;
         case ($urandom_range(0, 9))
            0:       ;
            1, 2, 3: w.sol = SOL_W'($urandom_range(1, SOLENOID_COUNT));
            default: w.sol = SOL_W'($urandom_range(1, 6));
         endcase
         case ($urandom_range(0, 9))
            0:       ;
            1, 2:    w.delay = LEN_W'($urandom_range(0, 300));
            default: w.delay = LEN_W'($urandom_range(0, 30));
         endcase
         case ($urandom_range(0, 9))
            0, 1:    w.width = '0;
            2:       ;
            default: w.width = LEN_W'($urandom_range(1, 25));
         endcase
      end else if (pick < 95) begin
         w.mode = MODE_TICK;
      end else if (pick < 97) begin
         w.mode = MODE_CLEAR;
      end else begin
         w.mode = MODE_NONE;
      end
      return w;
   endfunction

   task automatic send_word(input stim_row_type w);
      @(negedge clock);
      start        <= 1'b1;
      req_mode     <= w.mode;
      req_solenoid <= w.sol;
      req_delay_ms <= w.delay;
      req_width_ms <= w.width;
      row_typed    <= w.typed;
      row_want     <= w.want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic hold_off(input int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_all_results();
      hold_off(1);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_default_width(input logic [LEN_W-1:0] value);
      wait_all_results();
      @(negedge clock);
      csr_valid            <= 1'b1;
      csr_default_pulse_ms <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   stim_row_type directed [$];

   initial begin
      stim_row_type     w;
      int               sent;
      int               burst;
      logic [LEN_W-1:0] width_setting;

      // after reset: default width 20, counter 0
      directed.push_back(row(MODE_SCHEDULE, 0, 0, 0, 1, '0, 0, STATUS_BAD));
      directed.push_back(row(MODE_SCHEDULE, 33, 7, 7, 1, '0, 0, STATUS_BAD));
      directed.push_back(row(MODE_SCHEDULE, 63, 16'hFFFF, 16'hFFFF, 1, '0, 0, STATUS_BAD));
      directed.push_back(row(MODE_NONE, 63, 16'hFFFF, 16'hFFFF, 1, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_TICK, 0, 0, 0, 1, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_CLEAR, 0, 0, 0, 1, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_SCHEDULE, 1, 0, 0, 1, '0, 0, STATUS_SCHEDULED));
      // too close to the pending pulse of the same solenoid
      directed.push_back(row(MODE_SCHEDULE, 1, 19, 0, 1, '0, 0, STATUS_MERGED));
      directed.push_back(row(MODE_SCHEDULE, 1, 20, 0, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_SCHEDULE, 32, 0, 1, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_TICK, 0, 0, 0, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_TICK, 0, 0, 0, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_SCHEDULE, 1, 0, 0, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_SCHEDULE, 2, 16'hFFFF, 16'hFFFF, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_SCHEDULE, 2, 0, 16'h8000, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_CLEAR, 0, 0, 0, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_CLEAR, 0, 0, 0, 1, '0, 0, STATUS_DONE));
      // two fired pulses on one solenoid, the short one drops the bit
      directed.push_back(row(MODE_SCHEDULE, 3, 1, 5, 0, '0, 0, STATUS_DONE));
      directed.push_back(row(MODE_SCHEDULE, 3, 3, 1, 0, '0, 0, STATUS_DONE));
      repeat (5) directed.push_back(row(MODE_TICK, 0, 0, 0, 0, '0, 0, STATUS_DONE));

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_word(directed[i]);

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       width_setting = 16'd1;
            1:       width_setting = 16'hFFFF;
            2:       width_setting = 16'd0;
            3:       width_setting = LEN_W'($urandom_range(2, 16'hFFFE));
            4:       width_setting = 16'd3;
            default: width_setting = DEFAULT_PULSE_RESET;
         endcase
         write_default_width(width_setting);
         sent = 0;
         while (sent < PHASE_WORDS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
               w = random_word();
               send_word(w);
               if (w.mode != MODE_NONE)
                  sent++;
            end
            case ($urandom_range(0, 19))
               0:             wait_all_results();
               1, 2, 3, 4, 5: ;
               default:       hold_off($urandom_range(1, 45));
            endcase
         end
      end

      wait_all_results();
      if (mismatches == 0 && expected_results.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
